>>> design/dda_pkg.sv
// Shared types for the DDA line rasterizer.
// No dependencies; imported by dda_axis and dda_line_rasterizer_core.
package dda_pkg;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } dda_op_t;

    localparam int S_TDATA_WIDTH = 80;
    localparam int M_TDATA_WIDTH = 32;
    localparam int FIELD_WIDTH   = 16;

endpackage

>>> design/dda_axis.sv
// One axis of the DDA stepper: integer-plus-remainder update and rounding.
// Depends on dda_pkg.
module dda_axis
    import dda_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  dda_op_t                        op,
    input  logic signed [COORD_WIDTH-1:0]  coord_start,
    input  logic signed [COORD_WIDTH:0]    delta,
    input  logic        [COORD_WIDTH-1:0]  total,
    input  logic signed [COORD_WIDTH-1:0]  whole,
    input  logic        [COORD_WIDTH-1:0]  rem,
    output logic signed [COORD_WIDTH-1:0]  whole_next,
    output logic        [COORD_WIDTH-1:0]  rem_next,
    output logic        [7:0]              pix
);

    logic signed [COORD_WIDTH+1:0] sum;
    logic signed [COORD_WIDTH+1:0] tot_ext;
    logic signed [COORD_WIDTH+1:0] r_adv;
    logic signed [COORD_WIDTH-1:0] w_adv;
    logic        [COORD_WIDTH:0]   twice;
    logic                          round_up;

    always_comb
    begin
        sum     = $signed({2'b00, rem}) + $signed({delta[COORD_WIDTH], delta});
        tot_ext = $signed({2'b00, total});
        if (sum >= tot_ext)
        begin
            r_adv = sum - tot_ext;
            w_adv = whole + COORD_WIDTH'(1);
        end
        else if (sum < 0)
        begin
            r_adv = sum + tot_ext;
            w_adv = whole - COORD_WIDTH'(1);
        end
        else
        begin
            r_adv = sum;
            w_adv = whole;
        end
        // round to nearest, ties away from zero
        twice    = {r_adv[COORD_WIDTH-1:0], 1'b0};
        round_up = (total != '0) &&
                   ((twice > {1'b0, total}) ||
                    ((twice == {1'b0, total}) && !w_adv[COORD_WIDTH-1]));

        case (op)
            OP_START:
            begin
                whole_next = coord_start;
                rem_next   = '0;
                pix        = coord_start[7:0];
            end
            OP_ADVANCE:
            begin
                whole_next = w_adv;
                rem_next   = r_adv[COORD_WIDTH-1:0];
                pix        = w_adv[7:0] + {7'd0, round_up};
            end
            default:
            begin
                whole_next = whole;
                rem_next   = rem;
                pix        = '0;
            end
        endcase
    end

endmodule

>>> design/dda_line_rasterizer_core.sv
// DDA line rasterizer, one pixel per transfer. A start transfer (tuser 0) loads both
// endpoints and the color and returns pixel 0; each advance transfer (tuser 1) returns
// the next pixel, and tlast marks pixel number max(|dx|,|dy|). A zero-length line gives
// one pixel with tlast set. An advance with no line in progress returns an all-zero
// result with tuser 0. Each transfer passes an input register and a result register, and
// a new transfer is taken every cycle while the output is not stalled; the per-axis add,
// remainder correction and rounding compare between those registers set the clock.
// Depends on dda_pkg and dda_axis.
module dda_line_rasterizer_core
    import dda_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,
    // operation
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [M_TDATA_WIDTH-1:0] m_tdata,
    // pixel_valid
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int W = COORD_WIDTH;

    logic                   in_valid_reg;
    dda_op_t                in_op_reg;
    logic signed [W-1:0]    in_x0_reg, in_y0_reg, in_x1_reg, in_y1_reg;
    logic [FIELD_WIDTH-1:0] in_color_reg;

    logic                   busy_reg, busy_next;
    logic signed [W-1:0]    x_whole_reg, y_whole_reg;
    logic signed [W-1:0]    x_whole_next, y_whole_next;
    logic [W-1:0]           x_rem_reg, y_rem_reg, x_rem_next, y_rem_next;
    logic signed [W:0]      dx_reg, dy_reg, dx_next, dy_next;
    logic [W-1:0]           total_reg, total_next, idx_reg, idx_next;
    logic [FIELD_WIDTH-1:0] color_reg, color_next;

    logic                   out_valid_reg;
    logic [M_TDATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;
    logic                   out_last_reg, out_last_next;

    logic                   move;
    logic                   take;
    logic signed [W:0]      dx_start, dy_start;
    logic [W-1:0]           ax, ay, total_start;
    logic signed [W:0]      axis_dx, axis_dy;
    logic [W-1:0]           axis_total;
    logic [7:0]             pix_x, pix_y;
    logic [W-1:0]           idx_inc;

    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign take     = s_tvalid && s_tready;

    assign dx_start    = $signed({in_x1_reg[W-1], in_x1_reg}) - $signed({in_x0_reg[W-1], in_x0_reg});
    assign dy_start    = $signed({in_y1_reg[W-1], in_y1_reg}) - $signed({in_y0_reg[W-1], in_y0_reg});
    assign ax          = dx_start[W] ? W'(-dx_start) : dx_start[W-1:0];
    assign ay          = dy_start[W] ? W'(-dy_start) : dy_start[W-1:0];
    assign total_start = (ax > ay) ? ax : ay;

    assign axis_dx    = (in_op_reg == OP_START) ? dx_start : dx_reg;
    assign axis_dy    = (in_op_reg == OP_START) ? dy_start : dy_reg;
    assign axis_total = (in_op_reg == OP_START) ? total_start : total_reg;
    assign idx_inc    = idx_reg + W'(1);

    dda_axis #(.COORD_WIDTH(W)) u_axis_x
    (
        .op          (in_op_reg),
        .coord_start (in_x0_reg),
        .delta       (axis_dx),
        .total       (axis_total),
        .whole       (x_whole_reg),
        .rem         (x_rem_reg),
        .whole_next  (x_whole_next),
        .rem_next    (x_rem_next),
        .pix         (pix_x)
    );

    dda_axis #(.COORD_WIDTH(W)) u_axis_y
    (
        .op          (in_op_reg),
        .coord_start (in_y0_reg),
        .delta       (axis_dy),
        .total       (axis_total),
        .whole       (y_whole_reg),
        .rem         (y_rem_reg),
        .whole_next  (y_whole_next),
        .rem_next    (y_rem_next),
        .pix         (pix_y)
    );

    always_comb
    begin
        busy_next     = busy_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        color_next    = color_reg;
        out_data_next = '0;
        out_user_next = 1'b0;
        out_last_next = 1'b0;
        case (in_op_reg)
            OP_START:
            begin
                dx_next       = dx_start;
                dy_next       = dy_start;
                total_next    = total_start;
                idx_next      = '0;
                color_next    = in_color_reg;
                busy_next     = (total_start != '0);
                out_data_next = {in_color_reg, pix_y, pix_x};
                out_user_next = 1'b1;
                out_last_next = (total_start == '0);
            end
            OP_ADVANCE:
            begin
                if (busy_reg)
                begin
                    idx_next      = idx_inc;
                    busy_next     = !(idx_inc >= total_reg);
                    out_data_next = {color_reg, pix_y, pix_x};
                    out_user_next = 1'b1;
                    out_last_next = (idx_inc >= total_reg);
                end
            end
            default:
            begin
                busy_next = busy_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (move)
                in_valid_reg <= 1'b0;
            if (move)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= busy_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_op_reg    <= dda_op_t'(s_tuser);
            in_x0_reg    <= s_tdata[W-1:0];
            in_y0_reg    <= s_tdata[FIELD_WIDTH +: W];
            in_x1_reg    <= s_tdata[2*FIELD_WIDTH +: W];
            in_y1_reg    <= s_tdata[3*FIELD_WIDTH +: W];
            in_color_reg <= s_tdata[4*FIELD_WIDTH +: FIELD_WIDTH];
        end
        if (move)
        begin
            if ((in_op_reg == OP_START) || busy_reg)
            begin
                x_whole_reg <= x_whole_next;
                y_whole_reg <= y_whole_next;
                x_rem_reg   <= x_rem_next;
                y_rem_reg   <= y_rem_next;
            end
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            total_reg    <= total_next;
            idx_reg      <= idx_next;
            color_reg    <= color_next;
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_idx_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < total_reg))
        else $error("step index reached total while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((x_rem_reg < total_reg) && (y_rem_reg < total_reg)))
        else $error("axis remainder out of range");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last flag on an invalid pixel");

    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule
